// ----- sv/hsv2rgb_pkg.sv -----
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Shared types and constants for the HSV to RGB conversion pipeline.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

    localparam logic [6:0]  PCT_MAX    = 7'd100;
    localparam logic [8:0]  DEG_FULL   = 9'd360;
    localparam logic [8:0]  DEG_SEXT   = 9'd60;
    localparam logic [8:0]  DEG_THIRD  = 9'd120;

    // floor(h / 360) for any 16-bit h is (h * HUE_RECIP) >> HUE_SHIFT.
    localparam logic [15:0] HUE_RECIP  = 16'd46604;
    localparam int          HUE_SHIFT  = 24;

    // Terms are in units of 1/600000; 255/600000 reduces to 17/40000.
    localparam logic [12:0] V_SCALE    = 13'd6000;
    localparam logic [5:0]  C_SCALE    = 6'd60;
    localparam logic [4:0]  CH_MUL     = 5'd17;
    // floor(y / 40000) for y below 2^24 is (y * CH_RECIP) >> CH_SHIFT.
    localparam logic [24:0] CH_RECIP   = 25'd27487791;
    localparam int          CH_SHIFT   = 40;

    typedef enum logic [2:0] {
        SEC_RED_YEL,
        SEC_YEL_GRN,
        SEC_GRN_CYN,
        SEC_CYN_BLU,
        SEC_BLU_MAG,
        SEC_MAG_RED
    } sector_t;

    // After the coarse hue quotient.
    typedef struct packed {
        logic [15:0] hue;
        logic [7:0]  quot;
        logic [6:0]  sat;
        logic [6:0]  bri;
    } quot_t;

    // After sector selection.
    typedef struct packed {
        sector_t     sector;
        logic [5:0]  ramp;
        logic [13:0] vs;
        logic [6:0]  bri;
    } sect_t;

    typedef logic [19:0] frac_t;

    // Channel fractions in units of 1/600000.
    typedef struct packed {
        frac_t r;
        frac_t g;
        frac_t b;
    } mix_t;

endpackage

// ----- sv/hsv2rgb_sector.sv -----
// ----------------------------------------------------------------------------
// HSV to RGB hue sector stages
// Two register stages: hue quotient by 360 with saturation and value clamped to 100,
// then hue modulo 360, the sector, the ramp term and the value-saturation product.
// ----------------------------------------------------------------------------
module hsv2rgb_sector
    import hsv2rgb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] hue,
    input  logic [6:0]  saturation,
    input  logic [6:0]  brightness,
    output logic        sect_valid,
    input  logic        sect_ready,
    output sect_t       sect
);

    logic        q_valid_reg;
    quot_t       q_reg;
    quot_t       q_next;
    logic        q_adv;
    logic [31:0] hue_prod;

    logic        s_valid_reg;
    sect_t       s_reg;
    sect_t       s_next;
    logic        s_adv;
    logic [16:0] hue_base;
    logic [8:0]  hue_red;
    logic [8:0]  hue_mod;

    assign s_adv    = !s_valid_reg || sect_ready;
    assign q_adv    = !q_valid_reg || s_adv;
    assign in_ready = q_adv;

    always_comb
    begin
        hue_prod    = 32'(hue) * 32'(HUE_RECIP);
        q_next.hue  = hue;
        q_next.quot = hue_prod[HUE_SHIFT +: 8];
        q_next.sat  = (saturation > PCT_MAX) ? PCT_MAX : saturation;
        q_next.bri  = (brightness > PCT_MAX) ? PCT_MAX : brightness;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_valid_reg <= 1'b0;
        end
        else if (q_adv)
        begin
            q_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_adv && in_valid)
        begin
            q_reg <= q_next;
        end
    end

    always_comb
    begin
        hue_base = {1'b0, q_reg.hue} - 17'(q_reg.quot) * 17'(DEG_FULL);
        hue_red  = hue_base[8:0];

        if (hue_red < DEG_SEXT)
        begin
            s_next.sector = SEC_RED_YEL;
        end
        else if (hue_red < DEG_THIRD)
        begin
            s_next.sector = SEC_YEL_GRN;
        end
        else if (hue_red < 9'(DEG_THIRD + DEG_SEXT))
        begin
            s_next.sector = SEC_GRN_CYN;
        end
        else if (hue_red < 9'(2 * DEG_THIRD))
        begin
            s_next.sector = SEC_CYN_BLU;
        end
        else if (hue_red < 9'(2 * DEG_THIRD + DEG_SEXT))
        begin
            s_next.sector = SEC_BLU_MAG;
        end
        else
        begin
            s_next.sector = SEC_MAG_RED;
        end

        if (hue_red >= 9'(2 * DEG_THIRD))
        begin
            hue_mod = hue_red - 9'(2 * DEG_THIRD);
        end
        else if (hue_red >= DEG_THIRD)
        begin
            hue_mod = hue_red - DEG_THIRD;
        end
        else
        begin
            hue_mod = hue_red;
        end

        // The ramp rises over the first half of each 120-degree span and falls over the second.
        s_next.ramp = (hue_mod >= DEG_SEXT) ? 6'(DEG_THIRD - hue_mod) : hue_mod[5:0];
        s_next.vs   = 14'(q_reg.sat) * 14'(q_reg.bri);
        s_next.bri  = q_reg.bri;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
        end
        else if (s_adv)
        begin
            s_valid_reg <= q_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_adv && q_valid_reg)
        begin
            s_reg <= s_next;
        end
    end

    assign sect_valid = s_valid_reg;
    assign sect       = s_reg;

endmodule

// ----- sv/hsv2rgb_mix.sv -----
// ----------------------------------------------------------------------------
// HSV to RGB channel mix stage
// One register stage: forms chroma, ramp and offset and places them on
// the three channels according to the sector.
// ----------------------------------------------------------------------------
module hsv2rgb_mix
    import hsv2rgb_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  sect_valid,
    output logic  sect_ready,
    input  sect_t sect,
    output logic  mix_valid,
    input  logic  mix_ready,
    output mix_t  mix
);

    logic  m_valid_reg;
    mix_t  m_reg;
    mix_t  m_next;
    logic  m_adv;
    frac_t chroma;
    frac_t ramp;
    frac_t offset;

    assign m_adv      = !m_valid_reg || mix_ready;
    assign sect_ready = m_adv;

    always_comb
    begin
        chroma = 20'(sect.vs) * 20'(C_SCALE);
        ramp   = 20'(sect.vs) * 20'(sect.ramp);
        // Chroma never exceeds 6000 * v, so the offset stays non-negative.
        offset = 20'(sect.bri) * 20'(V_SCALE) - chroma;

        case (sect.sector)
            SEC_RED_YEL:
            begin
                m_next.r = chroma + offset;
                m_next.g = ramp + offset;
                m_next.b = offset;
            end
            SEC_YEL_GRN:
            begin
                m_next.r = ramp + offset;
                m_next.g = chroma + offset;
                m_next.b = offset;
            end
            SEC_GRN_CYN:
            begin
                m_next.r = offset;
                m_next.g = chroma + offset;
                m_next.b = ramp + offset;
            end
            SEC_CYN_BLU:
            begin
                m_next.r = offset;
                m_next.g = ramp + offset;
                m_next.b = chroma + offset;
            end
            SEC_BLU_MAG:
            begin
                m_next.r = ramp + offset;
                m_next.g = offset;
                m_next.b = chroma + offset;
            end
            default:
            begin
                m_next.r = chroma + offset;
                m_next.g = offset;
                m_next.b = ramp + offset;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (m_adv)
        begin
            m_valid_reg <= sect_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_adv && sect_valid)
        begin
            m_reg <= m_next;
        end
    end

    assign mix_valid = m_valid_reg;
    assign mix       = m_reg;

endmodule

// ----- sv/hsv2rgb_scale.sv -----
// ----------------------------------------------------------------------------
// HSV to RGB channel scale stages
// Two register stages: multiply each fraction by 17, then divide by 40000
// through a reciprocal multiply. The second stage is the output register.
// ----------------------------------------------------------------------------
module hsv2rgb_scale
    import hsv2rgb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       mix_valid,
    output logic       mix_ready,
    input  mix_t       mix,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] red,
    output logic [7:0] green,
    output logic [7:0] blue
);

    logic        y_valid_reg;
    logic [23:0] y_reg  [3];
    logic [23:0] y_next [3];
    logic        y_adv;
    frac_t       frac   [3];

    logic        o_valid_reg;
    logic [7:0]  o_reg  [3];
    logic [7:0]  o_next [3];
    logic        o_adv;
    logic [48:0] o_prod [3];

    assign o_adv     = !o_valid_reg || out_ready;
    assign y_adv     = !y_valid_reg || o_adv;
    assign mix_ready = y_adv;

    assign frac[0] = mix.r;
    assign frac[1] = mix.g;
    assign frac[2] = mix.b;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            y_next[i] = 24'(frac[i]) * 24'(CH_MUL);
            o_prod[i] = 49'(y_reg[i]) * 49'(CH_RECIP);
            o_next[i] = o_prod[i][CH_SHIFT +: 8];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            y_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (y_adv)
            begin
                y_valid_reg <= mix_valid;
            end
            if (o_adv)
            begin
                o_valid_reg <= y_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (y_adv && mix_valid)
            begin
                y_reg[i] <= y_next[i];
            end
            if (o_adv && y_valid_reg)
            begin
                o_reg[i] <= o_next[i];
            end
        end
    end

    assign out_valid = o_valid_reg;
    assign red       = o_reg[0];
    assign green     = o_reg[1];
    assign blue      = o_reg[2];

endmodule

// ----- sv/hsv_to_rgb_converter.sv -----
// Five register stages (quotient, sector, mix, product, output), each with its own valid bit.
// Throughput: one request per cycle while the output is not stalled.
// A stalled output holds its result while earlier stages keep filling empty slots.
// Reset (rst_n, asynchronous, active low) clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Converts hue, saturation and value to 8-bit red, green and blue.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter
    import hsv2rgb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] hue,
    input  logic [6:0]  saturation,
    input  logic [6:0]  brightness,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue
);

    logic  sect_valid;
    logic  sect_ready;
    sect_t sect;
    logic  mix_valid;
    logic  mix_ready;
    mix_t  mix;

    hsv2rgb_sector u_sector (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .sect_valid (sect_valid),
        .sect_ready (sect_ready),
        .sect       (sect)
    );

    hsv2rgb_mix u_mix (
        .clk        (clk),
        .rst_n      (rst_n),
        .sect_valid (sect_valid),
        .sect_ready (sect_ready),
        .sect       (sect),
        .mix_valid  (mix_valid),
        .mix_ready  (mix_ready),
        .mix        (mix)
    );

    hsv2rgb_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .mix_valid (mix_valid),
        .mix_ready (mix_ready),
        .mix       (mix),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .red       (red),
        .green     (green),
        .blue      (blue)
    );

endmodule

// ----- sv/hsv2rgb_checker.sv -----
// ----------------------------------------------------------------------------
// HSV to RGB converter checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module hsv2rgb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [15:0] hue,
    input logic [6:0]  saturation,
    input logic [6:0]  brightness,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  red,
    input logic [7:0]  green,
    input logic [7:0]  blue
);

    // Once reset has been seen at a clock edge, no result is shown.
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("result valid during reset");

    // A stalled result keeps its value until it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green)
            && $stable(blue))
        else $error("stalled result changed");

    // A waiting request keeps its payload until it is taken.
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(hue) && $stable(saturation)
            && $stable(brightness))
        else $error("waiting request changed");

    // With the output slot empty, every stage can move, so a request is taken.
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("request refused with empty output");

    // When the result is being taken the pipeline must also take a request.
    a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("request refused while output drains");

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_checker (.*);
